FILE: sv/pws_pkg.sv
// pws_pkg: transaction payload types and microcode program for phase_wait_statistics
// no dependencies; imported by the top level and its checker
`default_nettype none

package pws_pkg;

  localparam int OUT_W = 16;

  typedef struct packed {
    logic        func;
    logic [4:0]  phase;
    logic        is_red;
    logic        is_requested;
    logic [15:0] wait_timer;
    logic        green_start;
    logic        amber_end;
    logic        primary_green;
    logic        extending;
  } in_item_t;

  typedef struct packed {
    logic [4:0]       out_phase;
    logic [OUT_W-1:0] captured_wait;
    logic [OUT_W-1:0] max_wait;
    logic [OUT_W-1:0] mean_wait;
    logic             overstay;
    logic [OUT_W-1:0] overall_max;
  } out_item_t;

  // datapath operations, one per control word
  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_CAPTURE = 3'd1,
    OP_PUSH    = 3'd2,
    OP_DIV     = 3'd3,
    OP_MEAN    = 3'd4,
    OP_FINISH  = 3'd5,
    OP_EMIT    = 3'd6
  } uop_e;

  typedef enum logic [1:0] {
    COND_NEVER    = 2'd0,
    COND_BYPASS   = 2'd1,
    COND_NO_GREEN = 2'd2,
    COND_DIV_MORE = 2'd3
  } cond_e;

  typedef logic [2:0] step_t;

  localparam step_t STEP_READ    = 3'd0;
  localparam step_t STEP_CAPTURE = 3'd1;
  localparam step_t STEP_PUSH    = 3'd2;
  localparam step_t STEP_DIV     = 3'd3;
  localparam step_t STEP_MEAN    = 3'd4;
  localparam step_t STEP_FINISH  = 3'd5;
  localparam step_t STEP_EMIT    = 3'd6;

  typedef struct packed {
    uop_e  op;
    cond_e cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    case (s)
      STEP_READ:    w = '{op: OP_READ,    cond: COND_BYPASS,   target: STEP_EMIT};
      STEP_CAPTURE: w = '{op: OP_CAPTURE, cond: COND_NO_GREEN, target: STEP_FINISH};
      STEP_PUSH:    w = '{op: OP_PUSH,    cond: COND_NEVER,    target: STEP_READ};
      STEP_DIV:     w = '{op: OP_DIV,     cond: COND_DIV_MORE, target: STEP_DIV};
      STEP_MEAN:    w = '{op: OP_MEAN,    cond: COND_NEVER,    target: STEP_READ};
      STEP_FINISH:  w = '{op: OP_FINISH,  cond: COND_NEVER,    target: STEP_READ};
      STEP_EMIT:    w = '{op: OP_EMIT,    cond: COND_NEVER,    target: STEP_READ};
      default:      w = '{op: OP_EMIT,    cond: COND_NEVER,    target: STEP_READ};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: sv/pws_ram.sv
// pws_ram: generic single-clock RAM, one write port and one registered read port
// no dependencies
`default_nettype none

module pws_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: sv/phase_wait_statistics.sv
// phase_wait_statistics: per-phase wait capture, peak, windowed mean and overstay flag
// depends on pws_pkg and pws_ram
//
// usage: drive item_i and raise start; the transaction is taken on a clock edge with
// start high and busy low. busy then stays high while a microcoded sequencer walks
// the item through a plain datapath: a phase-state RAM (one word per phase, a valid
// bit per phase reads unwritten entries as zero), a sample RAM holding each phase's
// ring of WINDOW_DEPTH samples, and a restoring divider for the mean.
// one result per item appears on result_o for exactly one cycle with result_valid_o,
// in the cycle busy falls; the receiver cannot stall it.
// a clear item or an out-of-range phase jumps from the read step to emit, an update
// without green start goes from capture to finish, and one with green start runs push,
// the divider loop (one quotient bit per cycle over the SUM_W-bit running sum) and mean.
// a new item may be accepted in the cycle its predecessor's result is shown.
// reset clears the sequencer, the valid bits and the global maximum at once; a clear
// item does the same for the statistics. sample RAM contents are never reset.
`default_nettype none

module phase_wait_statistics
  import pws_pkg::*;
#(
  parameter int NUM_PHASES   = 32,
  parameter int WINDOW_DEPTH = 16,
  parameter int WAIT_BITS    = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start,
  output logic           busy,
  input  wire in_item_t  item_i,
  output logic           result_valid_o,
  output out_item_t      result_o
);

  localparam int VAL_W   = (WAIT_BITS < OUT_W) ? WAIT_BITS : OUT_W;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int POS_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int SUM_W   = VAL_W + $clog2(WINDOW_DEPTH);
  localparam int DC_W    = $clog2(SUM_W + 1);
  localparam int PH_AW   = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;
  localparam int SLOTS   = NUM_PHASES * WINDOW_DEPTH;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef struct packed {
    logic [VAL_W-1:0] cap;
    logic [VAL_W-1:0] peak;
    logic [CNT_W-1:0] cnt;
    logic [POS_W-1:0] pos;
    logic [SUM_W-1:0] sum;
    logic [VAL_W-1:0] mean;
    logic             ovr;
  } phase_state_t;

  localparam int ST_W = $bits(phase_state_t);

  // sequencer
  logic      busy_q, busy_d;
  step_t     step_q, step_d;
  ucode_t    uw;
  logic      take;

  // payload
  in_item_t               item_q, item_d;
  logic [VAL_W-1:0]       cap_q, cap_d, peak_q, peak_d, mean_q, mean_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d, rem_q, rem_d;
  logic [POS_W-1:0]       pos_q, pos_d;
  logic [SUM_W-1:0]       sum_q, sum_d, quo_q, quo_d, sum_base;
  logic                   ovr_q, ovr_d;
  logic [SLOT_AW-1:0]     slot_q, slot_d;
  logic [DC_W-1:0]        div_cnt_q, div_cnt_d;
  logic [CNT_W:0]         rem_sh;

  // control state
  logic [NUM_PHASES-1:0]  valid_q, valid_d;
  logic [VAL_W-1:0]       highest_q, highest_d;
  logic                   res_valid_q, res_valid_d;
  out_item_t              res_q, res_d;

  logic                   oor;
  logic [PH_AW-1:0]       ph_idx;
  logic [VAL_W-1:0]       timer_v;
  phase_state_t           st_rdata, st_ld, st_wdata;
  logic                   st_re, st_we, smp_re, smp_we;
  logic [VAL_W-1:0]       smp_rdata;

  assign oor     = (32'(item_q.phase) >= 32'(NUM_PHASES));
  assign ph_idx  = PH_AW'(item_q.phase);
  assign timer_v = item_q.wait_timer[VAL_W-1:0];
  assign uw      = ucode_rom(step_q);
  assign st_ld   = valid_q[ph_idx] ? st_rdata : '0;
  // the overstay flag is written back with its update of this step
  assign st_wdata = '{cap: cap_q, peak: peak_q, cnt: cnt_q, pos: pos_q,
                      sum: sum_q, mean: mean_q, ovr: ovr_d};

  pws_ram #(.WIDTH(ST_W), .DEPTH(NUM_PHASES), .AW(PH_AW)) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (ph_idx),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (ph_idx),
    .rdata_o (st_rdata)
  );

  pws_ram #(.WIDTH(VAL_W), .DEPTH(SLOTS), .AW(SLOT_AW)) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (smp_we),
    .waddr_i (slot_q),
    .wdata_i (cap_q),
    .re_i    (smp_re),
    .raddr_i (slot_d),
    .rdata_o (smp_rdata)
  );

  // jump condition of the current control word
  always_comb begin
    case (uw.cond)
      COND_BYPASS:   take = item_q.func || oor;
      COND_NO_GREEN: take = !item_q.green_start;
      COND_DIV_MORE: take = (div_cnt_q > DC_W'(1));
      default:       take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d      = busy_q;
    step_d      = step_q;
    item_d      = item_q;
    cap_d       = cap_q;
    peak_d      = peak_q;
    mean_d      = mean_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    sum_d       = sum_q;
    ovr_d       = ovr_q;
    slot_d      = slot_q;
    quo_d       = quo_q;
    rem_d       = rem_q;
    div_cnt_d   = div_cnt_q;
    valid_d     = valid_q;
    highest_d   = highest_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    st_re       = 1'b0;
    st_we       = 1'b0;
    smp_re      = 1'b0;
    smp_we      = 1'b0;
    sum_base    = sum_q;
    rem_sh      = {rem_q, quo_q[SUM_W-1]};

    if (!busy_q) begin
      if (start) begin
        busy_d = 1'b1;
        step_d = STEP_READ;
        item_d = item_i;
      end
    end else begin
      step_d = take ? uw.target : step_q + step_t'(1);
      case (uw.op)
        OP_READ: begin
          st_re = 1'b1;
        end
        OP_CAPTURE: begin
          cap_d  = st_ld.cap;
          peak_d = st_ld.peak;
          cnt_d  = st_ld.cnt;
          pos_d  = st_ld.pos;
          sum_d  = st_ld.sum;
          mean_d = st_ld.mean;
          ovr_d  = st_ld.ovr;
          if (item_q.is_red && item_q.is_requested) begin
            cap_d = timer_v;
            if (timer_v > st_ld.peak) begin
              peak_d = timer_v;
            end
          end
          // fetch the sample about to be overwritten in the ring
          slot_d = SLOT_AW'(32'(ph_idx) * WINDOW_DEPTH + 32'(st_ld.pos));
          smp_re = 1'b1;
        end
        OP_PUSH: begin
          if (cnt_q < CNT_W'(WINDOW_DEPTH)) begin
            cnt_d = cnt_q + CNT_W'(1);
          end else begin
            sum_base = sum_q - SUM_W'(smp_rdata);
          end
          sum_d     = sum_base + SUM_W'(cap_q);
          smp_we    = 1'b1;
          pos_d     = (32'(pos_q) >= WINDOW_DEPTH - 1) ? '0 : pos_q + POS_W'(1);
          quo_d     = sum_d;
          rem_d     = '0;
          div_cnt_d = DC_W'(SUM_W);
        end
        OP_DIV: begin
          // restoring division, one quotient bit per step
          if (rem_sh >= {1'b0, cnt_q}) begin
            rem_d = CNT_W'(rem_sh - {1'b0, cnt_q});
            quo_d = {quo_q[SUM_W-2:0], 1'b1};
          end else begin
            rem_d = rem_sh[CNT_W-1:0];
            quo_d = {quo_q[SUM_W-2:0], 1'b0};
          end
          div_cnt_d = div_cnt_q - DC_W'(1);
        end
        OP_MEAN: begin
          mean_d = quo_q[VAL_W-1:0];
          cap_d  = '0;
        end
        OP_FINISH: begin
          if (item_q.amber_end && item_q.primary_green && item_q.extending) begin
            ovr_d = 1'b1;
          end else if (item_q.amber_end || item_q.green_start) begin
            ovr_d = 1'b0;
          end
          if (peak_q > highest_q) begin
            highest_d = peak_q;
          end
          st_we            = 1'b1;
          valid_d[ph_idx]  = 1'b1;
        end
        OP_EMIT: begin
          busy_d            = 1'b0;
          res_valid_d       = 1'b1;
          res_d             = '0;
          res_d.out_phase   = item_q.phase;
          if (item_q.func) begin
            valid_d   = '0;
            highest_d = '0;
          end else if (oor) begin
            res_d.overall_max = OUT_W'(highest_q);
          end else begin
            res_d.captured_wait = OUT_W'(cap_q);
            res_d.max_wait      = OUT_W'(peak_q);
            res_d.mean_wait     = OUT_W'(mean_q);
            res_d.overstay      = ovr_q;
            res_d.overall_max   = OUT_W'(highest_q);
          end
        end
        default: begin
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= STEP_READ;
      valid_q     <= '0;
      highest_q   <= '0;
      res_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      busy_q      <= busy_d;
      step_q      <= step_d;
      valid_q     <= valid_d;
      highest_q   <= highest_d;
      res_valid_q <= res_valid_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    cap_q  <= cap_d;
    peak_q <= peak_d;
    mean_q <= mean_d;
    cnt_q  <= cnt_d;
    pos_q  <= pos_d;
    sum_q  <= sum_d;
    ovr_q  <= ovr_d;
    slot_q <= slot_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

FILE: sv/pws_checker.sv
// pws_checker: port-level assertions for phase_wait_statistics, bound to the top level
// depends on pws_pkg
`default_nettype none

module pws_checker
  import pws_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      start,
  input wire logic      busy,
  input wire in_item_t  item_i,
  input wire logic      result_valid_o,
  input wire out_item_t result_o
);

  // an accepted transaction occupies the block
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // busy drops exactly when the result is presented
  a_fall_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy fell without a result");

  // one result per transaction, never two in a row
  a_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy ##1 !result_valid_o)
    else $error("result strobe while busy or repeated");

  // statistics ordering: capture within peak, peak within global max
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (result_o.captured_wait <= result_o.max_wait) &&
                       (result_o.max_wait <= result_o.overall_max))
    else $error("statistics out of order");

  // a clear transaction answers with zeroed statistics
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && item_i.func |-> ##3 result_valid_o &&
      (result_o.overall_max == '0) && (result_o.max_wait == '0))
    else $error("clear did not zero statistics");

endmodule

bind phase_wait_statistics pws_checker u_pws_checker (.*);

`default_nettype wire
